// ===== src/morse_character_encoder_assert.svh =====
// Assertion helpers, sampled on clk and disabled while rst_n is low.
`ifndef MORSE_CHARACTER_ENCODER_ASSERT_SVH
`define MORSE_CHARACTER_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define MCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mce_pkg.sv =====
package mce_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ON,
        ST_GAP,
        ST_CLOSE
    } state_t;

    localparam logic [3:0] DOT_UNITS         = 4'd1;
    localparam logic [3:0] DASH_UNITS        = 4'd3;
    localparam logic [3:0] ELEMENT_GAP_UNITS = 4'd1;
    localparam logic [3:0] LETTER_GAP_UNITS  = 4'd5;
    localparam logic [3:0] UNKNOWN_ON_UNITS  = 4'd10;

    localparam logic [7:0] CODE_A     = 8'd97;
    localparam logic [7:0] CODE_Z     = 8'd122;
    localparam logic [7:0] CODE_THREE = 8'd51;
    localparam logic [7:0] CODE_FIVE  = 8'd53;
    localparam logic [7:0] CODE_ZERO  = 8'd48;

    // Entry: {element count[2:0], pattern[4:0]}; pattern bit 0 is sent first, 1 = dash.
    localparam logic [7:0] LETTER_TABLE [26] = '{
        {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
        {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
        {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
        {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
        {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
        {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
        {3'd4, 5'b01101}, {3'd4, 5'b00011}
    };

    localparam logic [7:0] THREE_ENTRY = {3'd5, 5'b11000};
    localparam logic [7:0] FIVE_ENTRY  = {3'd5, 5'b00000};
    localparam logic [7:0] ZERO_ENTRY  = {3'd5, 5'b11111};
    // Unknown code: one element, sent as the long on segment.
    localparam logic [7:0] UNKNOWN_ENTRY = {3'd1, 5'b00000};

    typedef struct packed
    {
        logic       unknown;
        logic [2:0] count;
        logic [4:0] pattern;
    } code_entry_t;

    // Shifter controls from the sequencer.
    typedef struct packed
    {
        logic load;
        logic shift;
    } shift_ctrl_t;

    // Current element as seen by the sequencer.
    typedef struct packed
    {
        logic dash;
        logic unknown;
        logic final_elem;
    } elem_status_t;

    function automatic code_entry_t lookup_code(input logic [7:0] code);
        code_entry_t entry;
        logic [7:0]  offset;
        entry  = '0;
        offset = code - CODE_A;
        if (code >= CODE_A && code <= CODE_Z)
        begin
            {entry.count, entry.pattern} = LETTER_TABLE[offset[4:0]];
        end
        else if (code == CODE_THREE)
        begin
            {entry.count, entry.pattern} = THREE_ENTRY;
        end
        else if (code == CODE_FIVE)
        begin
            {entry.count, entry.pattern} = FIVE_ENTRY;
        end
        else if (code == CODE_ZERO)
        begin
            {entry.count, entry.pattern} = ZERO_ENTRY;
        end
        else
        begin
            {entry.count, entry.pattern} = UNKNOWN_ENTRY;
            entry.unknown = 1'b1;
        end
        return entry;
    endfunction

endpackage

// ===== src/mce_shifter.sv =====
module mce_shifter
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               char_code,
    input  mce_pkg::shift_ctrl_t     ctrl,
    output mce_pkg::elem_status_t    status
);

    mce_pkg::code_entry_t entry;
    logic [4:0] pattern_reg;
    logic [4:0] pattern_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       unknown_reg;
    logic       unknown_next;

    assign entry = mce_pkg::lookup_code(char_code);

    always_comb
    begin
        pattern_next = pattern_reg;
        count_next   = count_reg;
        unknown_next = unknown_reg;
        if (ctrl.load)
        begin
            pattern_next = entry.pattern;
            count_next   = entry.count;
            unknown_next = entry.unknown;
        end
        else if (ctrl.shift)
        begin
            pattern_next = {1'b0, pattern_reg[4:1]};
            count_next   = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            unknown_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            unknown_reg <= unknown_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pattern_reg <= pattern_next;
    end

    assign status.dash       = pattern_reg[0];
    assign status.unknown    = unknown_reg;
    assign status.final_elem = (count_reg == 3'd1);

endmodule

// ===== src/morse_character_encoder.sv =====
// The first segment is emitted from ST_ON, entered on acceptance, through the output register.
// Throughput: a character of n elements gives 2n+1 segments, one per cycle
// without output stall; the next character is accepted only in ST_IDLE, after
// the closing gap is issued, so a new character waits until the last is done.
// The element shift register and segment sequencer set this rate.
// Reset (rst_n low, asynchronous): sequencer idle, no segment pending.
`include "morse_character_encoder_assert.svh"

module morse_character_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    output logic       seg_valid,
    input  logic       seg_stall,
    output logic       key_on,
    output logic [3:0] duration_units,
    output logic       last
);

    mce_pkg::state_t       state_reg;
    mce_pkg::state_t       state_next;
    mce_pkg::shift_ctrl_t  ctrl;
    mce_pkg::elem_status_t status;

    logic       advance;
    logic       emit;
    logic       emit_on;
    logic [3:0] emit_units;
    logic       emit_last;

    logic       seg_valid_reg;
    logic       seg_valid_next;
    logic       key_on_reg;
    logic [3:0] units_reg;
    logic       last_reg;

    mce_shifter u_shifter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .ctrl      (ctrl),
        .status    (status)
    );

    // Output register free or being drained this cycle.
    assign advance    = !seg_valid_reg || !seg_stall;
    assign char_stall = (state_reg != mce_pkg::ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mce_pkg::ST_IDLE:
            begin
                if (char_valid)
                begin
                    state_next = mce_pkg::ST_ON;
                end
            end
            mce_pkg::ST_ON:
            begin
                if (advance)
                begin
                    state_next = mce_pkg::ST_GAP;
                end
            end
            mce_pkg::ST_GAP:
            begin
                if (advance)
                begin
                    state_next = status.final_elem ? mce_pkg::ST_CLOSE : mce_pkg::ST_ON;
                end
            end
            mce_pkg::ST_CLOSE:
            begin
                if (advance)
                begin
                    state_next = mce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mce_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        ctrl       = '0;
        emit       = 1'b0;
        emit_on    = 1'b0;
        emit_units = mce_pkg::ELEMENT_GAP_UNITS;
        emit_last  = 1'b0;
        case (state_reg)
            mce_pkg::ST_IDLE:
            begin
                ctrl.load = char_valid;
            end
            mce_pkg::ST_ON:
            begin
                emit    = 1'b1;
                emit_on = 1'b1;
                if (status.unknown)
                begin
                    emit_units = mce_pkg::UNKNOWN_ON_UNITS;
                end
                else if (status.dash)
                begin
                    emit_units = mce_pkg::DASH_UNITS;
                end
                else
                begin
                    emit_units = mce_pkg::DOT_UNITS;
                end
            end
            mce_pkg::ST_GAP:
            begin
                emit       = 1'b1;
                ctrl.shift = advance;
            end
            mce_pkg::ST_CLOSE:
            begin
                emit       = 1'b1;
                emit_units = mce_pkg::LETTER_GAP_UNITS;
                emit_last  = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign seg_valid_next = advance ? emit : seg_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mce_pkg::ST_IDLE;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            key_on_reg <= emit_on;
            units_reg  <= emit_units;
            last_reg   <= emit_last;
        end
    end

    assign seg_valid      = seg_valid_reg;
    assign key_on         = key_on_reg;
    assign duration_units = units_reg;
    assign last           = last_reg;

    `MCE_ASSERT_NEXT(a_accept_starts_on, char_valid && !char_stall,
        state_reg == mce_pkg::ST_ON, "accepted transaction did not start an element")
    `MCE_ASSERT_NEXT(a_close_issues_last, (state_reg == mce_pkg::ST_CLOSE) && advance,
        seg_valid && last && !key_on, "closing gap not issued as last segment")
    `MCE_ASSERT_NOW(a_on_never_last, seg_valid && key_on,
        !last, "key-on segment marked last")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

typedef struct packed
{
    logic       key_on;
    logic [3:0] units;
    logic       last;
} segment_t;

class morse_scoreboard;

    localparam logic [3:0] DOT_LEN     = 4'd1;
    localparam logic [3:0] DASH_LEN    = 4'd3;
    localparam logic [3:0] ELEM_GAP    = 4'd1;
    localparam logic [3:0] LETTER_GAP  = 4'd5;
    localparam logic [3:0] UNKNOWN_LEN = 4'd10;

    segment_t pending_segs[$];
    int       errors;

    function new();
        errors = 0;
    endfunction

    // Empty string means the code has no Morse pattern.
    function string morse_pattern(input logic [7:0] code);
        string pat;
        pat = "";
        case (code)
            "a": pat = ".-";
            "b": pat = "-...";
            "c": pat = "-.-.";
            "d": pat = "-..";
            "e": pat = ".";
            "f": pat = "..-.";
            "g": pat = "--.";
            "h": pat = "....";
            "i": pat = "..";
            "j": pat = ".---";
            "k": pat = "-.-";
            "l": pat = ".-..";
            "m": pat = "--";
            "n": pat = "-.";
            "o": pat = "---";
            "p": pat = ".--.";
            "q": pat = "--.-";
            "r": pat = ".-.";
            "s": pat = "...";
            "t": pat = "-";
            "u": pat = "..-";
            "v": pat = "...-";
            "w": pat = ".--";
            "x": pat = "-..-";
            "y": pat = "-.--";
            "z": pat = "--..";
            "3": pat = "...--";
            "5": pat = ".....";
            "0": pat = "-----";
            default: pat = "";
        endcase
        return pat;
    endfunction

    function void push_seg(input logic on, input logic [3:0] units, input logic fin);
        segment_t s;
        s.key_on = on;
        s.units  = units;
        s.last   = fin;
        pending_segs.push_back(s);
    endfunction

    function void note_char(input logic [7:0] code);
        string pat;
        int    i;
        pat = morse_pattern(code);
        if (pat.len() == 0)
        begin
            push_seg(1'b1, UNKNOWN_LEN, 1'b0);
            push_seg(1'b0, ELEM_GAP, 1'b0);
        end
        else
        begin
            for (i = 0; i < pat.len(); i++)
            begin
                push_seg(1'b1, (pat[i] == "-") ? DASH_LEN : DOT_LEN, 1'b0);
                push_seg(1'b0, ELEM_GAP, 1'b0);
            end
        end
        push_seg(1'b0, LETTER_GAP, 1'b1);
    endfunction

    function void check_seg(input segment_t got);
        segment_t want;
        if (pending_segs.size() == 0)
        begin
            $display("%0t: unexpected segment transaction: key_on %b units %0d last %b",
                     $time, got.key_on, got.units, got.last);
            errors++;
            return;
        end
        want = pending_segs.pop_front();
        if (got.key_on !== want.key_on)
        begin
            $display("%0t: key_on mismatch: expected %b, actual %b",
                     $time, want.key_on, got.key_on);
            errors++;
        end
        if (got.units !== want.units)
        begin
            $display("%0t: duration_units mismatch: expected %0d, actual %0d",
                     $time, want.units, got.units);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, got.last);
            errors++;
        end
    endfunction

endclass

module testbench;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    logic [7:0] char_code;
    logic       seg_valid;
    logic       seg_stall;
    logic       key_on;
    logic [3:0] duration_units;
    logic       last;

    morse_scoreboard sb = new();

    // Both sides stop idling while set.
    logic quiet;
    int   chars_seen;
    logic hold_done;

    logic [7:0] directed_codes [25] = '{
        "a", "z", "e", "t", "0", "3", "5", "2", "A", "Z",
        8'd0, 8'd255, 8'd96, 8'd123, 8'd47, 8'd49, 8'd52, 8'd54,
        "q", "y", "j", "h", "m", 8'h80, 8'h7F
    };

    morse_character_encoder u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_code      (char_code),
        .seg_valid      (seg_valid),
        .seg_stall      (seg_stall),
        .key_on         (key_on),
        .duration_units (duration_units),
        .last           (last)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Sample both handshakes with the values in place before the edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (char_valid && !char_stall)
            begin
                sb.note_char(char_code);
                chars_seen++;
            end
            if (seg_valid && !seg_stall)
            begin
                sb.check_seg({key_on, duration_units, last});
            end
        end
    end

    task automatic send_char(input logic [7:0] code);
        int gap;
        char_valid <= 1'b1;
        char_code  <= code;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 99) < 37)
        begin
            gap = $urandom_range(1, 4);
            char_valid <= 1'b0;
            char_code  <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'(8'd97 + $urandom_range(0, 25));
        else if (r < 72)
        begin
            case ($urandom_range(0, 2))
                0: return "0";
                1: return "3";
                default: return "5";
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: random stall, plus one long hold-off to back the block up.
    initial
    begin
        seg_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && chars_seen >= 40)
            begin
                hold_done = 1'b1;
                seg_stall <= 1'b1;
                repeat (80) @(posedge clk);
            end
            else
            begin
                seg_stall <= !quiet && ($urandom_range(0, 99) < 37);
            end
        end
    end

    initial
    begin
        int i;
        quiet      = 1'b0;
        chars_seen = 0;
        hold_done  = 1'b0;
        rst_n      <= 1'b0;
        char_valid <= 1'b0;
        char_code  <= 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_codes[i])
            send_char(directed_codes[i]);

        for (i = 0; i < 105; i++)
        begin
            quiet = (i >= 60 && i < 100);
            send_char(pick_char());
        end
        quiet = 1'b0;
        char_valid <= 1'b0;

        while (sb.pending_segs.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
